[sv/assert_macros.svh]
// Assertion helper macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/wsp_pkg.sv]
// Shared constants, types and the divider step for the projection block.
// No dependencies.
`default_nettype none

package wsp_pkg;

    localparam int COORD_FRAC_DEF = 16;
    localparam int MAT_FRAC       = 13;
    localparam int COORD_W        = 32;
    localparam int ENTRY_W        = 16;
    localparam int ROW_W          = 48;
    localparam int PROD_W         = ENTRY_W + COORD_W;
    localparam int DOT_W          = 52;
    localparam int SIZE_W         = 14;
    localparam int P_W            = DOT_W + SIZE_W;
    localparam int QB             = 41;
    localparam int R_W            = 48;
    localparam int CFG_W          = 48;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RIGHT_ROW,
        CFG_UP_ROW,
        CFG_DEPTH_ROW,
        CFG_RIGHT_OFS,
        CFG_UP_OFS,
        CFG_DEPTH_OFS,
        CFG_SCREEN_W,
        CFG_SCREEN_H
    } cfg_idx_t;

    // One lane of the long division in flight.
    typedef struct packed {
        logic [DOT_W-1:0] rem;
        logic [QB-1:0]    lo;
        logic [QB-1:0]    quo;
        logic             ovf;
        logic             neg;
    } div_lane_t;

    // Per-point data that rides alongside both lanes.
    typedef struct packed {
        logic             behind;
        logic [DOT_W-1:0] den;
    } div_side_t;

    // One restoring-division step: bring in the next dividend bit.
    function automatic div_lane_t div_step(div_lane_t a, logic [DOT_W-1:0] den);
        div_lane_t        r;
        logic [DOT_W+1:0] diff;
        diff = {1'b0, a.rem, a.lo[QB-1]} - {2'b00, den};
        r = a;
        r.lo = {a.lo[QB-2:0], 1'b0};
        if (!diff[DOT_W+1])
        begin
            r.rem = diff[DOT_W-1:0];
            r.quo = {a.quo[QB-2:0], 1'b1};
        end
        else
        begin
            r.rem = {a.rem[DOT_W-2:0], a.lo[QB-1]};
            r.quo = {a.quo[QB-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/wsp_if.sv]
// Valid/ready channel interfaces for world points and screen results.
// No dependencies.
`default_nettype none

interface wsp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    modport source (output valid, world_x, world_y, world_z, input ready);
    modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface wsp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               behind_camera;
    modport source (output valid, screen_x, screen_y, behind_camera, input ready);
    modport sink   (input valid, screen_x, screen_y, behind_camera, output ready);
endinterface

`default_nettype wire

[sv/wsp_div_cell.sv]
// One cell of the divider chain: a quotient bit for both lanes per cycle while en is high.
// Depends on wsp_pkg.
`default_nettype none

module wsp_div_cell
    import wsp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      vld_in,
    input  wire div_lane_t x_in,
    input  wire div_lane_t y_in,
    input  wire div_side_t side_in,
    output logic           vld_out,
    output div_lane_t      x_out,
    output div_lane_t      y_out,
    output div_side_t      side_out
);

    logic      vld_reg;
    div_lane_t x_reg;
    div_lane_t y_reg;
    div_side_t side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= div_step(x_in, side_in.den);
            y_reg    <= div_step(y_in, side_in.den);
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

[sv/world_to_screen_projection_top.sv]
// Top level of the world-to-screen projection pipeline.
// Depends on wsp_pkg, wsp_if (wsp_in_if, wsp_out_if), wsp_div_cell, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Projects one world point per cycle to screen space. A word on pt_in
// (world_x/y/z, signed with COORD_FRAC_BITS fraction bits) comes out on
// pt_out after passing through its stages: three stages form the dot
// products and the product of the magnitude with the screen size, one
// stage sets up the division, 41 divider cells each resolve one quotient
// bit for x and y, and a last stage adds the half size and saturates. The
// whole pipe advances together, so a new word is taken every cycle while
// pt_out is ready or its register is empty; a held output holds the pipe.
// Points with depth below 0.098 give behind_camera=1 and zero coordinates.
// Configuration writes (cfg_we/cfg_index/cfg_data) must happen while the
// pipe is empty.
module world_to_screen_projection_top
    import wsp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    wsp_in_if.sink                    pt_in,
    wsp_out_if.source                 pt_out
);

    localparam int SHIFT  = COORD_FRAC_BITS - 1;
    localparam int DVD_W  = P_W + SHIFT;
    localparam int HALF_W = SIZE_W + SHIFT;
    // Largest depth still behind the camera: w*1000 < 98 << (frac bits).
    localparam longint NEAR_L = ((64'sd98 <<< (COORD_FRAC_BITS + MAT_FRAC)) - 1) / 1000;
    localparam logic signed [DOT_W-1:0] NEAR_MAX = DOT_W'(NEAR_L);
    localparam logic [QB-1:0] TERM_CAP = {1'b1, {(QB-1){1'b0}}};
    localparam logic signed [R_W-1:0] S32_MAX = R_W'(64'sh7FFF_FFFF);
    localparam logic signed [R_W-1:0] S32_MIN = -R_W'(64'sh8000_0000);

    // ---------------- configuration ----------------
    logic [ROW_W-1:0]         right_row_reg, up_row_reg, depth_row_reg;
    logic signed [COORD_W-1:0] right_ofs_reg, up_ofs_reg, depth_ofs_reg;
    logic [SIZE_W-1:0]        width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_row_reg <= '0;
            up_row_reg    <= '0;
            depth_row_reg <= '0;
            right_ofs_reg <= '0;
            up_ofs_reg    <= '0;
            depth_ofs_reg <= '0;
            width_reg     <= SIZE_W'(1920);
            height_reg    <= SIZE_W'(1080);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RIGHT_ROW: right_row_reg <= cfg_data[ROW_W-1:0];
                CFG_UP_ROW:    up_row_reg    <= cfg_data[ROW_W-1:0];
                CFG_DEPTH_ROW: depth_row_reg <= cfg_data[ROW_W-1:0];
                CFG_RIGHT_OFS: right_ofs_reg <= cfg_data[COORD_W-1:0];
                CFG_UP_OFS:    up_ofs_reg    <= cfg_data[COORD_W-1:0];
                CFG_DEPTH_OFS: depth_ofs_reg <= cfg_data[COORD_W-1:0];
                CFG_SCREEN_W:  width_reg     <= cfg_data[SIZE_W-1:0];
                CFG_SCREEN_H:  height_reg    <= cfg_data[SIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic out_vld_reg;
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;

    assign en          = !out_vld_reg || pt_out.ready;
    assign pt_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= pt_in.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // ---------------- stage 1: nine products ----------------
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic [ROW_W-1:0]         rows [3];
    logic signed [COORD_W-1:0] coords [3];

    assign rows[0]   = right_row_reg;
    assign rows[1]   = up_row_reg;
    assign rows[2]   = depth_row_reg;
    assign coords[0] = pt_in.world_x;
    assign coords[1] = pt_in.world_y;
    assign coords[2] = pt_in.world_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= PROD_W'($signed(rows[r][ENTRY_W*c +: ENTRY_W]))
                                      * PROD_W'(coords[c]);
                end
            end
        end
    end

    // ---------------- stage 2: dot products plus offsets ----------------
    logic signed [DOT_W-1:0]   dot_next [3];
    logic signed [DOT_W-1:0]   dot_reg  [3];
    logic signed [COORD_W-1:0] offs [3];

    assign offs[0] = right_ofs_reg;
    assign offs[1] = up_ofs_reg;
    assign offs[2] = depth_ofs_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            dot_next[r] = {{(DOT_W-COORD_W-MAT_FRAC){offs[r][COORD_W-1]}}, offs[r],
                           {MAT_FRAC{1'b0}}};
            for (int c = 0; c < 3; c++)
            begin
                dot_next[r] = dot_next[r]
                    + {{(DOT_W-PROD_W){prod_reg[r][c][PROD_W-1]}}, prod_reg[r][c]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                dot_reg[r] <= dot_next[r];
            end
        end
    end

    // ---------------- stage 3: near test, magnitude times size ----------------
    logic [DOT_W-1:0] mag_x, mag_y;
    logic [P_W-1:0]   px_reg, py_reg;
    logic             negx_reg, negy_reg;
    div_side_t        side3_reg;

    assign mag_x = dot_reg[0][DOT_W-1] ? DOT_W'(-dot_reg[0]) : DOT_W'(dot_reg[0]);
    assign mag_y = dot_reg[1][DOT_W-1] ? DOT_W'(-dot_reg[1]) : DOT_W'(dot_reg[1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg           <= P_W'(mag_x) * P_W'(width_reg);
            py_reg           <= P_W'(mag_y) * P_W'(height_reg);
            negx_reg         <= dot_reg[0][DOT_W-1];
            negy_reg         <= dot_reg[1][DOT_W-1];
            side3_reg.behind <= (dot_reg[2] <= NEAR_MAX);
            side3_reg.den    <= dot_reg[2];
        end
    end

    // ---------------- stage 4: division setup ----------------
    logic [DVD_W-1:0] dvd_x, dvd_y;
    logic [DOT_W-1:0] hi_x, hi_y;
    div_lane_t        lx_next, ly_next;
    div_lane_t        lx_reg, ly_reg;
    div_side_t        side4_reg;

    assign dvd_x = {px_reg, {SHIFT{1'b0}}};
    assign dvd_y = {py_reg, {SHIFT{1'b0}}};
    assign hi_x  = DOT_W'(dvd_x >> QB);
    assign hi_y  = DOT_W'(dvd_y >> QB);

    always_comb
    begin
        lx_next.rem = hi_x;
        lx_next.lo  = dvd_x[QB-1:0];
        lx_next.quo = '0;
        lx_next.ovf = (hi_x >= side3_reg.den);
        lx_next.neg = negx_reg;
        ly_next.rem = hi_y;
        ly_next.lo  = dvd_y[QB-1:0];
        ly_next.quo = '0;
        ly_next.ovf = (hi_y >= side3_reg.den);
        ly_next.neg = !negy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lx_reg    <= lx_next;
            ly_reg    <= ly_next;
            side4_reg <= side3_reg;
        end
    end

    // ---------------- divider cell chain ----------------
    logic      cv   [QB+1];
    div_lane_t cx   [QB+1];
    div_lane_t cy   [QB+1];
    div_side_t cs   [QB+1];
    logic [QB+4:0] vld_vec;

    assign cv[0] = s4_vld_reg;
    assign cx[0] = lx_reg;
    assign cy[0] = ly_reg;
    assign cs[0] = side4_reg;

    for (genvar g = 0; g < QB; g++)
    begin : g_cell
        wsp_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (cv[g]),
            .x_in     (cx[g]),
            .y_in     (cy[g]),
            .side_in  (cs[g]),
            .vld_out  (cv[g+1]),
            .x_out    (cx[g+1]),
            .y_out    (cy[g+1]),
            .side_out (cs[g+1])
        );
        assign vld_vec[g] = cv[g+1];
    end

    assign vld_vec[QB+4:QB] = {out_vld_reg, s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg};

    // ---------------- final stage: half size plus term, saturate ----------------
    logic [QB-1:0]          qx, qy;
    logic [HALF_W-1:0]      half_x, half_y;
    logic signed [R_W-1:0]  rx, ry;
    logic signed [COORD_W-1:0] sx_next, sy_next;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg;
    logic                   out_behind_reg;

    assign qx     = (cx[QB].ovf || cx[QB].quo > TERM_CAP) ? TERM_CAP : cx[QB].quo;
    assign qy     = (cy[QB].ovf || cy[QB].quo > TERM_CAP) ? TERM_CAP : cy[QB].quo;
    assign half_x = {width_reg, {SHIFT{1'b0}}};
    assign half_y = {height_reg, {SHIFT{1'b0}}};

    always_comb
    begin
        rx = cx[QB].neg ? $signed(R_W'(half_x)) - $signed(R_W'(qx))
                        : $signed(R_W'(half_x)) + $signed(R_W'(qx));
        ry = cy[QB].neg ? $signed(R_W'(half_y)) - $signed(R_W'(qy))
                        : $signed(R_W'(half_y)) + $signed(R_W'(qy));
        priority if (rx > S32_MAX)      sx_next = S32_MAX[COORD_W-1:0];
        else if (rx < S32_MIN)          sx_next = S32_MIN[COORD_W-1:0];
        else                            sx_next = rx[COORD_W-1:0];
        priority if (ry > S32_MAX)      sy_next = S32_MAX[COORD_W-1:0];
        else if (ry < S32_MIN)          sy_next = S32_MIN[COORD_W-1:0];
        else                            sy_next = ry[COORD_W-1:0];
        if (cs[QB].behind)
        begin
            sx_next = '0;
            sy_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= cv[QB];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg      <= sx_next;
            out_y_reg      <= sy_next;
            out_behind_reg <= cs[QB].behind;
        end
    end

    assign pt_out.valid         = out_vld_reg;
    assign pt_out.screen_x      = out_x_reg;
    assign pt_out.screen_y      = out_y_reg;
    assign pt_out.behind_camera = out_behind_reg;

    // ---------------- checks ----------------
    `ASSERT_IMPL(a_behind_zero, clk, rst_n, out_vld_reg && out_behind_reg, out_x_reg == '0 && out_y_reg == '0, "behind-camera word with nonzero coordinates")
    `ASSERT_IMPL(a_ready_rule, clk, rst_n, 1'b1, pt_in.ready == (!out_vld_reg || pt_out.ready), "input ready does not follow output stall")
    `ASSERT_NEXT(a_hold_pipe, clk, rst_n, !en, $stable(vld_vec), "pipe moved while output stalled")

endmodule

`default_nettype wire
